// ----- hdl/hse_pkg.sv -----
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants of the heap sort engine
// Command and status words between controller and datapath, store selects.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;

  // store read address select
  typedef enum logic [2:0] {
    RA_H    = 3'd0,  // heapify start node
    RA_LC   = 3'd1,  // left child of current node
    RA_RC   = 3'd2,  // right child of current node
    RA_I    = 3'd3,  // end of heap during extraction
    RA_ROOT = 3'd4,  // root
    RA_K    = 3'd5   // output index
  } rd_sel_t;

  // store write select
  typedef enum logic [2:0] {
    WR_NONE = 3'd0,
    WR_LOAD = 3'd1,  // input word at fill count
    WR_CUR  = 3'd2,  // sifted word into its final slot
    WR_BEST = 3'd3,  // larger child moves up
    WR_ROOT = 3'd4   // old root to end of heap
  } wr_sel_t;

  typedef struct packed {
    wr_sel_t wr_sel;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    setup;        // latch set size, heapify start, extraction end
    logic    cur_from_rd;  // sift word from read data
    logic    best_left;    // left child becomes candidate
    logic    best_right;   // right child replaces candidate if larger
    logic    pos_to_h;
    logic    pos_to_best;
    logic    pos_to_root;
    logic    len_to_i;
    logic    h_dec;
    logic    i_dec;
    logic    emit;         // read next output word
    logic    set_done;     // clear fill count and overflow flag
  } hse_cmd_t;

  typedef struct packed {
    logic lc_in;        // left child inside heap
    logic rc_in;        // right child inside heap
    logic best_gt_cur;  // larger child beats sift word
    logic n_small;      // fewer than two words held
    logic h_zero;
    logic i_one;
    logic k_last;
  } hse_sts_t;

endpackage

`default_nettype wire

// ----- hdl/hse_datapath.sv -----
// ----------------------------------------------------------------------------
// hse_datapath: element store, sift registers and output register
// Single write port and single registered read port on the store.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_datapath
  import hse_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire hse_cmd_t                 cmd,
  output hse_sts_t                      sts,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_strobe,
  output logic signed [DATA_W-1:0]      out_sorted_value,
  output logic                          out_end_of_set,
  output logic                          out_overflow
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;  // child index width, holds 2*DEPTH

  logic [DATA_W-1:0] store_mem [DEPTH];

  logic [CW-1:0]     count_r;
  logic              ovf_r;
  logic [CW-1:0]     len_r;
  logic [AW-1:0]     h_r;
  logic [AW-1:0]     i_r;
  logic [AW-1:0]     k_r;
  logic [AW-1:0]     pos_r;
  logic [DATA_W-1:0] cur_r;
  logic [DATA_W-1:0] best_r;
  logic [AW-1:0]     best_idx_r;
  logic [DATA_W-1:0] rd_q_r;
  logic              emit_d1_r;
  logic              last_d1_r;
  logic              out_strobe_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_eos_r;
  logic              out_ovf_r;

  logic [XW-1:0]     lc;
  logic [XW-1:0]     rc;
  logic              full;
  logic              rd_gt_best;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign lc         = XW'({pos_r, 1'b1});
  assign rc         = lc + XW'(1);
  assign full       = (count_r == CW'(DEPTH));
  assign rd_gt_best = $signed(rd_q_r) > $signed(best_r);

  assign sts.lc_in       = lc < XW'(len_r);
  assign sts.rc_in       = rc < XW'(len_r);
  assign sts.best_gt_cur = $signed(best_r) > $signed(cur_r);
  assign sts.n_small     = count_r < CW'(2);
  assign sts.h_zero      = (h_r == '0);
  assign sts.i_one       = (i_r == AW'(1));
  assign sts.k_last      = (CW'(k_r) + CW'(1)) == count_r;

  always_comb begin
    case (cmd.rd_sel)
      RA_H:    rd_addr = h_r;
      RA_LC:   rd_addr = lc[AW-1:0];
      RA_RC:   rd_addr = rc[AW-1:0];
      RA_I:    rd_addr = i_r;
      RA_ROOT: rd_addr = '0;
      RA_K:    rd_addr = k_r;
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = cur_r;
    unique case (cmd.wr_sel)
      WR_NONE: wr_en = 1'b0;
      WR_LOAD: begin
        wr_en   = !full;
        wr_addr = count_r[AW-1:0];
        wr_data = in_value;
      end
      WR_CUR:  wr_en = 1'b1;
      WR_BEST: begin
        wr_en   = 1'b1;
        wr_data = best_r;
      end
      WR_ROOT: begin
        wr_en   = 1'b1;
        wr_addr = i_r;
        wr_data = rd_q_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= store_mem[rd_addr];
    end
  end

  // fill count and overflow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.set_done) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.wr_sel == WR_LOAD) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // sift and loop registers
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      len_r <= count_r;
      h_r   <= AW'((count_r >> 1) - CW'(1));
      i_r   <= AW'(count_r - CW'(1));
      k_r   <= '0;
    end else begin
      if (cmd.len_to_i) len_r <= CW'(i_r);
      if (cmd.h_dec)    h_r   <= h_r - AW'(1);
      if (cmd.i_dec)    i_r   <= i_r - AW'(1);
      if (cmd.emit)     k_r   <= k_r + AW'(1);
    end
    if (cmd.pos_to_h) begin
      pos_r <= h_r;
    end else if (cmd.pos_to_best) begin
      pos_r <= best_idx_r;
    end else if (cmd.pos_to_root) begin
      pos_r <= '0;
    end
    if (cmd.cur_from_rd) cur_r <= rd_q_r;
    if (cmd.best_left) begin
      best_r     <= rd_q_r;
      best_idx_r <= lc[AW-1:0];
    end else if (cmd.best_right && rd_gt_best) begin
      best_r     <= rd_q_r;
      best_idx_r <= rc[AW-1:0];
    end
  end

  // output register, loaded from the registered store read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_d1_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      emit_d1_r    <= cmd.emit;
      out_strobe_r <= emit_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    last_d1_r <= cmd.emit && sts.k_last;
    if (emit_d1_r) begin
      out_value_r <= rd_q_r;
      out_eos_r   <= last_d1_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_set   = out_eos_r;
  assign out_overflow     = out_ovf_r;

  a_eos_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_eos_r |=> !out_strobe_r)
    else $error("word after end of set");

  a_swap_moves_down: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_sel == WR_BEST |-> best_idx_r > pos_r)
    else $error("sift moved to a node that is not a child");

  a_rc_inside_heap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en && cmd.rd_sel == RA_RC |-> sts.rc_in)
    else $error("right child read outside heap");

endmodule

`default_nettype wire

// ----- hdl/hse_ctrl.sv -----
// ----------------------------------------------------------------------------
// hse_ctrl: sequencer of the heap sort engine
// Loads words, runs heapify and extraction sift passes, streams the result.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_ctrl
  import hse_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     in_last,
  output logic          busy,
  output hse_cmd_t      cmd,
  input  wire hse_sts_t sts
);

  typedef enum logic [13:0] {
    ST_IDLE   = 14'h0001,
    ST_SETUP  = 14'h0002,
    ST_B_RD   = 14'h0004,  // read heapify node
    ST_B_CUR  = 14'h0008,
    ST_CHK    = 14'h0010,  // sift step: test left child
    ST_LC     = 14'h0020,
    ST_RC     = 14'h0040,
    ST_CMP    = 14'h0080,
    ST_NEXT   = 14'h0100,
    ST_X_RD   = 14'h0200,  // read end of heap
    ST_X_ROOT = 14'h0400,
    ST_X_SWAP = 14'h0800,
    ST_EMIT   = 14'h1000,
    ST_DONE   = 14'h2000
  } state_t;

  state_t state_r, state_nxt;
  logic   build_r, build_nxt;

  always_comb begin
    state_nxt = state_r;
    build_nxt = build_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.wr_sel = WR_LOAD;
          if (in_last) state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        build_nxt = 1'b1;
        state_nxt = sts.n_small ? ST_EMIT : ST_B_RD;
      end
      ST_B_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RA_H;
        cmd.pos_to_h = 1'b1;
        state_nxt    = ST_B_CUR;
      end
      ST_B_CUR: begin
        cmd.cur_from_rd = 1'b1;
        state_nxt       = ST_CHK;
      end
      ST_CHK: begin
        if (sts.lc_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_LC;
          state_nxt  = ST_LC;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = ST_NEXT;
        end
      end
      ST_LC: begin
        cmd.best_left = 1'b1;
        if (sts.rc_in) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_RC;
          state_nxt  = ST_RC;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_RC: begin
        cmd.best_right = 1'b1;
        state_nxt      = ST_CMP;
      end
      ST_CMP: begin
        if (sts.best_gt_cur) begin
          cmd.wr_sel      = WR_BEST;
          cmd.pos_to_best = 1'b1;
          state_nxt       = ST_CHK;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_nxt  = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (build_r) begin
          if (sts.h_zero) begin
            build_nxt = 1'b0;
            state_nxt = ST_X_RD;
          end else begin
            cmd.h_dec = 1'b1;
            state_nxt = ST_B_RD;
          end
        end else if (sts.i_one) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.i_dec = 1'b1;
          state_nxt = ST_X_RD;
        end
      end
      ST_X_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_I;
        state_nxt  = ST_X_ROOT;
      end
      ST_X_ROOT: begin
        cmd.cur_from_rd = 1'b1;
        cmd.rd_en       = 1'b1;
        cmd.rd_sel      = RA_ROOT;
        state_nxt       = ST_X_SWAP;
      end
      ST_X_SWAP: begin
        cmd.wr_sel      = WR_ROOT;
        cmd.pos_to_root = 1'b1;
        cmd.len_to_i    = 1'b1;
        state_nxt       = ST_CHK;
      end
      ST_EMIT: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RA_K;
        cmd.emit   = 1'b1;
        if (sts.k_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.set_done = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      build_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      build_r <= build_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_busy_ends_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(state_r) == ST_DONE)
    else $error("busy dropped before the run finished");

endmodule

`default_nettype wire

// ----- hdl/heap_sort_engine_core.sv -----
// ----------------------------------------------------------------------------
// heap_sort_engine_core: collecting in-place heap sorter for signed words
// Top level joining the sequencer and the store datapath.
// ----------------------------------------------------------------------------
// Words are written while busy is low, one per cycle (start high, busy low).
// The word with in_last high closes the set and busy rises. Up to DEPTH words
// are kept; later words of the same set are dropped and every result of the
// set then has out_overflow high. The set is heap sorted in the store, then
// streamed out ascending, one word per cycle on out_strobe, the final one with
// out_end_of_set. The receiver cannot stall: each result is valid for exactly
// one cycle. Sort time is set by the store's single read port: a sift level
// reads the children one at a time, compares, then writes back; extraction
// moves the old root to the end of the heap and sifts the end word down from
// the root. busy drops in the cycle the last result is shown, and a new set
// may start right then.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_engine_core
  import hse_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF  // store depth, 2 to 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input words
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [DATA_W-1:0] in_value,
  input  wire logic                     in_last,
  // sorted words
  output logic                          out_strobe,
  output logic signed [DATA_W-1:0]      out_sorted_value,
  output logic                          out_end_of_set,
  output logic                          out_overflow
);

  hse_cmd_t cmd;
  hse_sts_t sts;

  // controller: load, heapify, extraction and stream sequencing
  hse_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_last),
    .busy    (busy),
    .cmd     (cmd),
    .sts     (sts)
  );

  // datapath: store, sift registers, output register
  hse_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_sorted_value (out_sorted_value),
    .out_end_of_set   (out_end_of_set),
    .out_overflow     (out_overflow)
  );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the heap sort engine core
// Sends sets of signed words (directed extremes, one-word sets, duplicates,
// presorted runs, a full store, an overflowing set, a drain pause, then
// random sets, most under random sender gaps) and checks every result against
// a heap-sort predictor of the open set's store, fill count and overflow flag.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hse_pkg::*;

  localparam int SORT_DEPTH  = DEPTH_DEF;
  // A full set sorts with nothing moving on either port, so the limit is set
  // above its sort time before a quiet spell is called a hang.
  localparam int STALL_LIMIT = 20000;
  // Results leave one per cycle, so a short tail is enough to catch strays.
  localparam int TAIL_CYCLES = 100;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     end_of_set;
    logic                     overflow;
  } sorted_word_t;

  // DUT ports; every input known from time zero
  logic                     clk      = 1'b0;
  logic                     rst_n    = 1'b0;
  logic                     start    = 1'b0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     in_last  = 1'b0;
  logic                     busy;
  logic                     out_strobe;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_end_of_set;
  logic                     out_overflow;

  // predictor state: words of the open set, fill count, dropped-word flag
  logic signed [DATA_W-1:0] held_words [SORT_DEPTH];
  int                       held_count    = 0;
  logic                     held_overflow = 1'b0;
  sorted_word_t             pending_sorted [$];

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  bit  idle_on        = 1'b1;

  heap_sort_engine_core #(.DEPTH(SORT_DEPTH)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_value        (in_value),
    .in_last         (in_last),
    .out_strobe      (out_strobe),
    .out_sorted_value(out_sorted_value),
    .out_end_of_set  (out_end_of_set),
    .out_overflow    (out_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: max-heap sift-down over the held words of the open set.
  // --------------------------------------------------------------------------
  function automatic void sift_heap(int node, int heap_len);
    int                       largest;
    int                       child;
    logic signed [DATA_W-1:0] swap_word;
    bit                       settled;
    settled = 1'b0;
    while (!settled) begin
      largest = node;
      child   = 2 * node + 1;
      if (child < heap_len && held_words[child] > held_words[largest])
        largest = child;
      if (child + 1 < heap_len && held_words[child + 1] > held_words[largest])
        largest = child + 1;
      if (largest == node) begin
        settled = 1'b1;
      end else begin
        swap_word           = held_words[node];
        held_words[node]    = held_words[largest];
        held_words[largest] = swap_word;
        node                = largest;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge, before the DUT's own
  // updates of that edge land, so an accepted word and a shown result are
  // the values of the cycle that the edge ends. The word is folded into the
  // predictor first, then the result is checked, always in that order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic                     accepted;
    logic                     shown;
    logic signed [DATA_W-1:0] swap_word;
    sorted_word_t             want;
    accepted = rst_n && start && !busy;
    shown    = rst_n && (out_strobe !== 1'b0);

    if (accepted) begin
      // store full: word dropped, but its last mark still closes the set
      if (held_count < SORT_DEPTH) begin
        held_words[held_count] = in_value;
        held_count++;
      end else begin
        held_overflow = 1'b1;
      end
      if (in_last) begin
        // build the heap, then move the root to the shrinking end
        for (int h = held_count / 2 - 1; h >= 0; h--)
          sift_heap(h, held_count);
        for (int e = held_count - 1; e > 0; e--) begin
          swap_word     = held_words[0];
          held_words[0] = held_words[e];
          held_words[e] = swap_word;
          sift_heap(0, e);
        end
        for (int k = 0; k < held_count; k++) begin
          want.value      = held_words[k];
          want.end_of_set = (k == held_count - 1);
          want.overflow   = held_overflow;
          pending_sorted.push_back(want);
        end
        held_count    = 0;
        held_overflow = 1'b0;
      end
    end

    if (shown) begin
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual value=%0d eos=%b ovf=%b",
                 $time, out_sorted_value, out_end_of_set, out_overflow);
        mismatch_count++;
      end else begin
        want = pending_sorted.pop_front();
        if (out_sorted_value !== want.value) begin
          $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                   $time, want.value, out_sorted_value);
          mismatch_count++;
        end
        if (out_end_of_set !== want.end_of_set) begin
          $display("%0t: end_of_set mismatch: expected %b, actual %b",
                   $time, want.end_of_set, out_end_of_set);
          mismatch_count++;
        end
        if (out_overflow !== want.overflow) begin
          $display("%0t: overflow mismatch: expected %b, actual %b",
                   $time, want.overflow, out_overflow);
          mismatch_count++;
        end
      end
    end

    quiet_cycles <= (accepted || shown) ? 0 : quiet_cycles + 1;
  end

  // Watchdog: nothing accepted on either side for too long means a hang,
  // or results that never came.
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Mix of full-range words, a narrow band for duplicates, and the extremes.
  function automatic logic signed [DATA_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return $urandom_range(1) ? WORD_MAX : WORD_MIN;
      1, 2:    return int'($urandom_range(8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word and hold it until accepted. Without gaps start stays high
  // on return, so the next call follows without a bubble; park_input lowers it.
  // With idling on, gap cycles follow with junk on the data ports.
  task automatic send_word(input logic signed [DATA_W-1:0] word, input logic closes);
    start    <= 1'b1;
    in_value <= word;
    in_last  <= closes;
    @(posedge clk);
    while (busy) @(posedge clk);
    while (idle_on && $urandom_range(99) < 27) begin
      start    <= 1'b0;
      in_value <= $urandom;
      in_last  <= 1'($urandom_range(1));
      @(posedge clk);
    end
  endtask

  task automatic park_input();
    start   <= 1'b0;
    in_last <= 1'b0;
  endtask

  // Hold the sender back until every predicted word has come out. One edge
  // first, so the monitor has folded in the word accepted at this edge.
  task automatic wait_drained();
    park_input();
    @(posedge clk);
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  task automatic send_set(input int set_len);
    for (int j = 0; j < set_len; j++)
      send_word(rand_word(), j == set_len - 1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes and alternating bit patterns in one set.
  task automatic test_extremes();
    send_word(WORD_MAX, 1'b0);
    send_word(WORD_MIN, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word(32'sh5555_5555, 1'b0);
    send_word(32'shAAAA_AAAA, 1'b0);
    send_word(1, 1'b1);
  endtask

  // One-word sets skip the sort entirely.
  task automatic test_single_word();
    send_word(WORD_MIN, 1'b1);
    send_word(WORD_MAX, 1'b1);
  endtask

  task automatic test_duplicates();
    send_word(3, 1'b0);
    send_word(-3, 1'b0);
    send_word(3, 1'b0);
    send_word(3, 1'b0);
    send_word(WORD_MIN, 1'b0);
    send_word(WORD_MIN, 1'b1);
  endtask

  // Two sets that are already ascending, the second of negative words.
  task automatic test_presorted();
    for (int j = 1; j <= 4; j++) send_word(j, j == 4);
    for (int j = 4; j >= 1; j--) send_word(-j * 1000, j == 1);
  endtask

  // Exactly DEPTH words: store full, nothing dropped.
  task automatic test_full_store();
    send_set(SORT_DEPTH);
  endtask

  // Two words past DEPTH; the dropped closing word still ends the set.
  task automatic test_overflow();
    send_set(SORT_DEPTH + 2);
  endtask

  // A set, a full drain with the sender held off, then another set.
  task automatic test_drain_pause();
    send_set(5);
    wait_drained();
    send_set(3);
  endtask

  // Random sets, mostly short. The first third runs without sender gaps.
  task automatic test_random_sets(input int word_budget);
    int sent;
    int set_len;
    sent    = 0;
    idle_on = 1'b0;
    while (sent < word_budget) begin
      if (sent >= word_budget / 3) idle_on = 1'b1;
      set_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_set(set_len);
      sent += set_len;
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence: synchronous reset, then the tests in turn, then drain and a
  // short tail to catch any stray word.
  // --------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_single_word();
    test_duplicates();
    test_presorted();
    test_full_store();
    test_overflow();
    test_drain_pause();
    test_random_sets(170);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_sorted.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/hse_pkg.sv
hdl/hse_datapath.sv
hdl/hse_ctrl.sv
hdl/heap_sort_engine_core.sv
bench/tb_top.sv
